// ===== hdl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Types and constants shared by the step pulse generator modules.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
  localparam int unsigned REG_WIDTH           = 16;
  localparam int unsigned CFG_INDEX_WIDTH     = 2;
  localparam int unsigned IN_DATA_WIDTH       = 40;
  localparam int unsigned OUT_DATA_WIDTH      = 40;

  localparam logic [REG_WIDTH-1:0] PULSE_HIGH_RESET  = 16'd0;
  localparam logic [REG_WIDTH-1:0] STEP_PERIOD_RESET = 16'd1;
  localparam logic [REG_WIDTH-1:0] FAR_END_RESET     = 16'd60000;
  localparam logic [REG_WIDTH-1:0] POSITION_MAX      = 16'hFFFF;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_HIGH  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAR_END     = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [REG_WIDTH-1:0] step_count;
    logic                 move_forward;
    logic [REG_WIDTH-1:0] target_position;
    logic                 back_limit;
    logic                 front_limit;
  } spg_item_t;

  typedef struct packed {
    logic                 step_level;
    logic [REG_WIDTH-1:0] position_now;
    logic [REG_WIDTH-1:0] steps_remaining;
    logic                 driver_wake;
    logic                 step_done;
  } spg_result_t;

endpackage

// ===== hdl/spg_input_stage.sv =====
// ----------------------------------------------------------------------------
// spg_input_stage
// Input register of the stream: holds one accepted item until it is processed.
// ----------------------------------------------------------------------------
module spg_input_stage
  import spg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_WIDTH-1:0] s_tdata,
  input  logic                     s_tuser,
  input  logic                     advance,
  output logic                     item_valid,
  output spg_item_t                item
);

  logic load;

  assign s_tready = !item_valid || advance;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.kind            <= s_tuser;
      item.step_count      <= s_tdata[15:0];
      item.move_forward    <= s_tdata[16];
      item.target_position <= s_tdata[32:17];
      item.back_limit      <= s_tdata[33];
      item.front_limit     <= s_tdata[34];
    end
  end

endmodule

// ===== hdl/spg_step_engine.sv =====
// ----------------------------------------------------------------------------
// spg_step_engine
// Motion state, configuration registers and the per-item update logic.
// ----------------------------------------------------------------------------
module spg_step_engine
  import spg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data,
  input  logic                       advance,
  input  spg_item_t                  item,
  output spg_result_t                result
);

  localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

  logic [REG_WIDTH-1:0]   pulse_high;
  logic [REG_WIDTH-1:0]   step_period;
  logic [REG_WIDTH-1:0]   far_end;

  logic [COUNT_WIDTH-1:0] phase_count;
  logic [REG_WIDTH-1:0]   steps_left;
  logic [REG_WIDTH-1:0]   position;
  logic                   direction_forward;
  logic [REG_WIDTH-1:0]   target;
  logic                   pin_level;

  logic [COUNT_WIDTH-1:0] phase_count_next;
  logic [REG_WIDTH-1:0]   steps_left_next;
  logic [REG_WIDTH-1:0]   position_next;
  logic                   direction_forward_next;
  logic [REG_WIDTH-1:0]   target_next;
  logic                   pin_level_next;

  logic [COUNT_WIDTH-1:0] phase_inc;
  logic [CMP_WIDTH-1:0]   phase_ext;
  logic [REG_WIDTH-1:0]   moved;
  logic                   wake;
  logic                   done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_high  <= PULSE_HIGH_RESET;
      step_period <= STEP_PERIOD_RESET;
      far_end     <= FAR_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_HIGH:  pulse_high  <= cfg_data;
        REG_STEP_PERIOD: step_period <= cfg_data;
        REG_FAR_END:     far_end     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign phase_inc = phase_count + COUNT_WIDTH'(1);
  assign phase_ext = CMP_WIDTH'(phase_inc);

  always_comb begin
    moved = position;
    if (direction_forward) begin
      if (position != POSITION_MAX) begin
        moved = position + REG_WIDTH'(1);
      end
    end else if (position != '0) begin
      moved = position - REG_WIDTH'(1);
    end
    if (item.front_limit) begin
      moved = far_end;
    end else if (item.back_limit) begin
      moved = '0;
    end
  end

  always_comb begin
    phase_count_next       = phase_count;
    steps_left_next        = steps_left;
    position_next          = position;
    direction_forward_next = direction_forward;
    target_next            = target;
    pin_level_next         = pin_level;
    wake                   = 1'b0;
    done                   = 1'b0;
    if (item.kind == KIND_START) begin
      steps_left_next        = item.step_count;
      direction_forward_next = item.move_forward;
      target_next            = item.target_position;
      phase_count_next       = '0;
    end else if (steps_left != '0) begin
      wake             = 1'b1;
      phase_count_next = phase_inc;
      priority if (phase_ext <= CMP_WIDTH'(pulse_high)) begin
        pin_level_next = 1'b1;
      end else if (phase_ext < CMP_WIDTH'(step_period)) begin
        pin_level_next = 1'b0;
      end else if (phase_ext == CMP_WIDTH'(step_period)) begin
        done             = 1'b1;
        phase_count_next = '0;
        pin_level_next   = 1'b0;
        position_next    = moved;
        if (moved == target) begin
          steps_left_next = '0;
        end else begin
          steps_left_next = steps_left - REG_WIDTH'(1);
        end
      end else begin
        // Past the period without a match the pin keeps its level.
        pin_level_next = pin_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count       <= '0;
      steps_left        <= '0;
      position          <= '0;
      direction_forward <= 1'b0;
      target            <= '0;
      pin_level         <= 1'b0;
    end else if (advance) begin
      phase_count       <= phase_count_next;
      steps_left        <= steps_left_next;
      position          <= position_next;
      direction_forward <= direction_forward_next;
      target            <= target_next;
      pin_level         <= pin_level_next;
    end
  end

  assign result.step_level      = pin_level_next;
  assign result.position_now    = position_next;
  assign result.steps_remaining = steps_left_next;
  assign result.driver_wake     = wake;
  assign result.step_done       = done;

endmodule

// ===== hdl/spg_output_stage.sv =====
// ----------------------------------------------------------------------------
// spg_output_stage
// Result register of the stream: holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module spg_output_stage
  import spg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  spg_result_t               result,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_WIDTH-1:0] m_tdata,
  output logic                      can_load
);

  spg_result_t held;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result;
    end
  end

  assign m_tdata = {5'd0, held.step_done, held.driver_wake, held.steps_remaining,
                    held.position_now, held.step_level};

endmodule

// ===== hdl/stepper_step_pulse_generator_core.sv =====
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_core
// Step pulse generator with position counter for a stepper motor driver.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream: tuser selects a timer tick (0) or a start
// move command (1), and tdata carries the move parameters and limit switches.
// Every item yields exactly one result on the master stream, carrying the pin
// level, the position, the steps left and the wake and step completion flags.
// An accepted item is held in an input register; once the result register can
// load, the step logic updates the motion state from it and loads the result
// register, which then offers the result to the receiver. One item is accepted
// and one result produced in every cycle while the receiver takes each result,
// as each item makes a single pass through the step logic. While the receiver
// stalls, the input register can still take one more item if it is empty,
// after which tready falls until the result is taken.
// The configuration port writes a register on each clock edge with the write
// enable high; writes to the spare index are ignored. Reset clears the motion
// state and both stream registers and restores the register defaults.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_core
  import spg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // step_count[15:0], move_forward[16], target_position[32:17],
  // back_limit[33], front_limit[34], zero fill[39:35]
  input  logic [IN_DATA_WIDTH-1:0]   s_tdata,
  // kind[0]
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // step_level[0], position_now[16:1], steps_remaining[32:17],
  // driver_wake[33], step_done[34], zero fill[39:35]
  output logic [OUT_DATA_WIDTH-1:0]  m_tdata
);

  logic        item_valid;
  logic        can_load;
  logic        advance;
  spg_item_t   item;
  spg_result_t result;

  assign advance = item_valid && can_load;

  spg_input_stage u_input_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  spg_step_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  spg_output_stage u_output_stage (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .can_load (can_load)
  );

endmodule
